[sv/npcs_pkg.sv]
`default_nettype none

package npcs_pkg;

  localparam int PAL_ENTRIES_DEFAULT   = 256;
  localparam int RESERVE_SLOTS_DEFAULT = 5;
  localparam int SLOT_REGS             = 5;

  localparam int CHAN_W   = 8;
  localparam int COLOUR_W = 3 * CHAN_W;
  localparam int POS_W    = 9;
  localparam int SQ_W     = 2 * CHAN_W;
  localparam int DIST_W   = 18;
  localparam int SLOT_W   = 18;
  localparam int OUT_W    = 8;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int REG_SEL_W  = 3;

  localparam logic [REG_SEL_W-1:0] REG_READY      = 3'd0;
  localparam logic [REG_SEL_W-1:0] REG_SLOT_FIRST = 3'd1;
  localparam logic [REG_SEL_W-1:0] REG_SLOT_LAST  = 3'd5;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic STATUS_DONE      = 1'b0;
  localparam logic STATUS_NOT_READY = 1'b1;

  localparam logic [OUT_W-1:0]  NOT_READY_INDEX = 8'd7;
  localparam logic [DIST_W-1:0] BEST_START      = 18'd200000;

  localparam int SLOT_ACTIVE_BIT = 17;

  typedef logic [SLOT_W-1:0] slot_t;

endpackage

`default_nettype wire

[sv/npcs_ram.sv]
`default_nettype none

module npcs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[sv/nearest_palette_colour_search.sv]
// A write transaction stores one palette entry. A query transaction scans its window one
// palette memory read per cycle; a query while the palette is not ready skips the scan and
// goes straight to the result. The scan is bound by the single read port of the palette
// memory. The block takes a new transaction whenever it is idle, even while an earlier
// result still waits in the output register. Entries never written read as black, as
// after reset, without any clearing pass.
`default_nettype none

module nearest_palette_colour_search
  import npcs_pkg::*;
#(
  parameter int PALETTE_ENTRIES = PAL_ENTRIES_DEFAULT,
  parameter int RESERVE_SLOTS   = RESERVE_SLOTS_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // entry_index, red, green, blue, range_start, range_count, skip_reserved, zero fill
  input  wire logic [55:0]           in_tdata,
  // action
  input  wire logic                  in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // nearest_index
  output logic      [OUT_W-1:0]      out_tdata,
  // status
  output logic                       out_tuser,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  localparam int IDX_W = $clog2(PALETTE_ENTRIES);
  localparam logic [POS_W-1:0] LIMIT = POS_W'(PALETTE_ENTRIES);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_RESULT} state_t;

  function automatic logic [POS_W-1:0] sat_end(input logic [CHAN_W-1:0] first,
                                               input logic [POS_W-1:0] count);
    logic [POS_W:0] e;
    e = {2'b00, first} + {1'b0, count};
    return (e > {1'b0, LIMIT}) ? LIMIT : e[POS_W-1:0];
  endfunction

  function automatic logic [SQ_W-1:0] sq_diff(input logic [CHAN_W-1:0] a,
                                               input logic [CHAN_W-1:0] b);
    logic [CHAN_W-1:0] d;
    d = (a > b) ? a - b : b - a;
    return d * d;
  endfunction

  logic [CHAN_W-1:0] f_entry, f_red, f_green, f_blue, f_start;
  logic [POS_W-1:0]  f_count;
  logic              f_skip;

  assign f_entry = in_tdata[7:0];
  assign f_red   = in_tdata[15:8];
  assign f_green = in_tdata[23:16];
  assign f_blue  = in_tdata[31:24];
  assign f_start = in_tdata[39:32];
  assign f_count = in_tdata[48:40];
  assign f_skip  = in_tdata[49];

  // Configuration registers.
  logic                 ready_r;
  slot_t                slot_r [SLOT_REGS];
  logic [REG_SEL_W-1:0] reg_sel;
  logic                 cfg_wr;

  assign reg_sel    = cfg_paddr[CFG_ADDR_W-1:2];
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r <= 1'b0;
      for (int s = 0; s < SLOT_REGS; s++) begin
        slot_r[s] <= '0;
      end
    end else if (cfg_wr) begin
      if (reg_sel == REG_READY) begin
        ready_r <= cfg_pwdata[0];
      end else if (reg_sel >= REG_SLOT_FIRST && reg_sel <= REG_SLOT_LAST) begin
        slot_r[reg_sel - REG_SLOT_FIRST] <= cfg_pwdata[SLOT_W-1:0];
      end
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (reg_sel == REG_READY) begin
      cfg_prdata = {{(CFG_DATA_W-1){1'b0}}, ready_r};
    end else if (reg_sel >= REG_SLOT_FIRST && reg_sel <= REG_SLOT_LAST) begin
      cfg_prdata = {{(CFG_DATA_W-SLOT_W){1'b0}}, slot_r[reg_sel - REG_SLOT_FIRST]};
    end
  end

  // Search state.
  state_t                 state_r, state_nxt;
  logic [POS_W-1:0]       idx_r, idx_nxt;
  logic [POS_W-1:0]       end_r, end_nxt;
  logic [CHAN_W-1:0]      q_red_r, q_red_nxt;
  logic [CHAN_W-1:0]      q_green_r, q_green_nxt;
  logic [CHAN_W-1:0]      q_blue_r, q_blue_nxt;
  logic                   skip_r, skip_nxt;
  logic                   p1_v_r, p1_v_nxt;
  logic                   p1_ok_r, p1_ok_nxt;
  logic [POS_W-1:0]       p1_idx_r, p1_idx_nxt;
  logic                   p2_v_r, p2_v_nxt;
  logic [POS_W-1:0]       p2_idx_r, p2_idx_nxt;
  logic [SQ_W-1:0]        sq_r_r, sq_r_nxt;
  logic [SQ_W-1:0]        sq_g_r, sq_g_nxt;
  logic [SQ_W-1:0]        sq_b_r, sq_b_nxt;
  logic [DIST_W-1:0]      best_r, best_nxt;
  logic [POS_W-1:0]       best_idx_r, best_idx_nxt;
  logic                   status_r, status_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]       out_data_r, out_data_nxt;
  logic                   out_user_r, out_user_nxt;
  logic [PALETTE_ENTRIES-1:0] valid_r, valid_nxt;

  logic                   in_acc;
  logic                   issue;
  logic                   reserved;
  logic                   ram_we;
  logic [COLOUR_W-1:0]    ram_rdata;
  logic [COLOUR_W-1:0]    colour;
  logic [DIST_W-1:0]      cand_dist;

  npcs_ram #(
    .WIDTH (COLOUR_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk   (clk),
    .we    (ram_we),
    .waddr (f_entry[IDX_W-1:0]),
    .wdata ({f_blue, f_green, f_red}),
    .raddr (idx_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid & in_tready;
  assign ram_we     = in_acc && (in_tuser == ACT_WRITE) && ({1'b0, f_entry} < LIMIT);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  always_comb begin
    logic [CHAN_W-1:0] first;
    logic [POS_W-1:0]  stop;
    reserved = 1'b0;
    for (int s = 0; s < RESERVE_SLOTS && s < SLOT_REGS; s++) begin
      first = slot_r[s][CHAN_W-1:0];
      stop  = sat_end(first, slot_r[s][SLOT_ACTIVE_BIT-1:CHAN_W]);
      if (slot_r[s][SLOT_ACTIVE_BIT] && idx_r >= {1'b0, first} && idx_r < stop) begin
        reserved = 1'b1;
      end
    end
  end

  assign issue     = (state_r == ST_SCAN) && (idx_r < end_r);
  assign colour    = p1_ok_r ? ram_rdata : '0;
  assign cand_dist = DIST_W'(sq_r_r) + DIST_W'(sq_g_r) + DIST_W'(sq_b_r);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    end_nxt       = end_r;
    q_red_nxt     = q_red_r;
    q_green_nxt   = q_green_r;
    q_blue_nxt    = q_blue_r;
    skip_nxt      = skip_r;
    best_nxt      = best_r;
    best_idx_nxt  = best_idx_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    valid_nxt     = valid_r;

    p1_v_nxt   = issue && !(skip_r && reserved);
    p1_idx_nxt = idx_r;
    p1_ok_nxt  = valid_r[idx_r[IDX_W-1:0]];
    p2_v_nxt   = p1_v_r;
    p2_idx_nxt = p1_idx_r;
    sq_r_nxt   = sq_diff(colour[CHAN_W-1:0], q_red_r);
    sq_g_nxt   = sq_diff(colour[2*CHAN_W-1:CHAN_W], q_green_r);
    sq_b_nxt   = sq_diff(colour[COLOUR_W-1:2*CHAN_W], q_blue_r);

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (ram_we) begin
      valid_nxt[f_entry[IDX_W-1:0]] = 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_tuser == ACT_QUERY) begin
          q_red_nxt   = f_red;
          q_green_nxt = f_green;
          q_blue_nxt  = f_blue;
          skip_nxt    = f_skip;
          if (ready_r) begin
            idx_nxt      = {1'b0, f_start};
            end_nxt      = sat_end(f_start, f_count);
            best_nxt     = BEST_START;
            best_idx_nxt = '0;
            status_nxt   = STATUS_DONE;
            state_nxt    = ST_SCAN;
          end else begin
            best_idx_nxt = {1'b0, NOT_READY_INDEX};
            status_nxt   = STATUS_NOT_READY;
            state_nxt    = ST_RESULT;
          end
        end
      end
      ST_SCAN: begin
        if (issue) begin
          idx_nxt = idx_r + 1'b1;
        end
        if (p2_v_r && cand_dist < best_r) begin
          best_nxt     = cand_dist;
          best_idx_nxt = p2_idx_r;
        end
        if (!issue && !p1_v_r && !p2_v_r) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = best_idx_r[OUT_W-1:0];
          out_user_nxt  = status_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      p1_v_r      <= p1_v_nxt;
      p2_v_r      <= p2_v_nxt;
      out_valid_r <= out_valid_nxt;
      valid_r     <= valid_nxt;
    end
    idx_r      <= idx_nxt;
    end_r      <= end_nxt;
    q_red_r    <= q_red_nxt;
    q_green_r  <= q_green_nxt;
    q_blue_r   <= q_blue_nxt;
    skip_r     <= skip_nxt;
    p1_ok_r    <= p1_ok_nxt;
    p1_idx_r   <= p1_idx_nxt;
    p2_idx_r   <= p2_idx_nxt;
    sq_r_r     <= sq_r_nxt;
    sq_g_r     <= sq_g_nxt;
    sq_b_r     <= sq_b_nxt;
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

endmodule

`default_nettype wire
